/* src/partitioned_block_convolver_core_assert.svh */
// Assertion macros used by the convolver controller RTL.
`ifndef PARTITIONED_BLOCK_CONVOLVER_CORE_ASSERT_SVH
`define PARTITIONED_BLOCK_CONVOLVER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Implication checked on every clock edge outside reset.
`define PBC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define PBC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PBC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* src/pbc_pkg.sv */
// ----------------------------------------------------------------------------
// pbc_pkg: shared constants and types
// Sizes of the tap and history memories and controller/datapath interfaces.
// ----------------------------------------------------------------------------
`default_nettype none
package pbc_pkg;
	localparam int MAX_TAPS  = 4096;
	localparam int BLOCK_LEN = 64;
	localparam int HIST_LEN  = MAX_TAPS + BLOCK_LEN;
	localparam int TAP_AW    = $clog2(MAX_TAPS);
	localparam int LEN_W     = $clog2(MAX_TAPS + 1);
	localparam int HIST_AW   = $clog2(HIST_LEN);
	localparam int FILL_W    = $clog2(HIST_LEN + 1);
	localparam int POS_W     = $clog2(BLOCK_LEN);
	localparam int PART_W    = $clog2(MAX_TAPS / BLOCK_LEN + 1);
	localparam int SMP_W     = 24;
	localparam int ACC_W     = 64;
	localparam int IRL_W     = 13;

	// request kinds carried on tuser
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TAP    = 1'b1;

	// controller commands to the datapath
	typedef struct packed {
		logic smp_store;   // audio word accepted: load output, store sample
		logic tap_store;   // tap word accepted
		logic blk_start;   // start computing a block
		logic row_start;   // start one output of the block
		logic mac_issue;   // issue one tap/sample read
		logic row_finish;  // round, saturate and store one output
	} pbc_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic parts_zero;  // silent state
		logic pos_last;    // current word closes the block
		logic k_last;      // last tap of the row issued now
		logic n_last;      // last output of the block
	} pbc_sts_t;
endpackage
`default_nettype wire

/* src/pbc_ctrl.sv */
// ----------------------------------------------------------------------------
// pbc_ctrl: convolver sequencer
// Handshake control and the per-block multiply-accumulate schedule.
// ----------------------------------------------------------------------------
`default_nettype none
`include "partitioned_block_convolver_core_assert.svh"
module pbc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_kind,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire pbc_pkg::pbc_sts_t sts,
	output pbc_pkg::pbc_cmd_t      cmd
);
	import pbc_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SETTLE, S_ROW, S_MAC, S_DRAIN, S_FIN} state_t;

	state_t state_q;
	logic   drain_q;
	logic   in_fire;

	// accept only when idle and the output register is free
	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		cmd            = '0;
		cmd.smp_store  = in_fire && (in_kind == REQ_SAMPLE);
		cmd.tap_store  = in_fire && (in_kind == REQ_TAP);
		cmd.blk_start  = cmd.smp_store && !sts.parts_zero && sts.pos_last;
		cmd.row_start  = (state_q == S_ROW);
		cmd.mac_issue  = (state_q == S_MAC);
		cmd.row_finish = (state_q == S_FIN);
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			drain_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.smp_store)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.smp_store)
						state_q <= cmd.blk_start ? S_ROW : S_SETTLE;
				end
				S_SETTLE: state_q <= S_IDLE;
				S_ROW:    state_q <= S_MAC;
				S_MAC: begin
					if (sts.k_last) begin
						state_q <= S_DRAIN;
						drain_q <= 1'b0;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q)
						state_q <= S_FIN;
				end
				S_FIN:    state_q <= sts.n_last ? S_SETTLE : S_ROW;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	`PBC_ASSERT(a_ready_idle, clk, arst_n, in_ready |-> state_q == S_IDLE, "ready outside idle")
	`PBC_ASSERT(a_mac_live, clk, arst_n, state_q == S_MAC |-> !sts.parts_zero, "mac while silent")
	`PBC_ASSERT(a_blk_end, clk, arst_n, (state_q == S_FIN && sts.n_last) |=> state_q == S_SETTLE,
		"block end not settled")
endmodule
`default_nettype wire

/* src/pbc_datapath.sv */
// ----------------------------------------------------------------------------
// pbc_datapath: memories, counters and MAC pipeline
// Tap store, sample history, output block and the rounding/saturation stage.
// ----------------------------------------------------------------------------
`default_nettype none
module pbc_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pbc_pkg::pbc_cmd_t              cmd,
	output pbc_pkg::pbc_sts_t                   sts,
	input  wire logic                           cfg_we,
	input  wire logic [pbc_pkg::IRL_W-1:0]      cfg_wdata,
	input  wire logic signed [pbc_pkg::SMP_W-1:0] sample,
	input  wire logic [pbc_pkg::TAP_AW-1:0]     tap_index,
	input  wire logic signed [pbc_pkg::SMP_W-1:0] tap_value,
	output logic signed [pbc_pkg::SMP_W-1:0]    out_sample,
	output logic                                clipped
);
	import pbc_pkg::*;

	logic signed [SMP_W-1:0] tap_mem [MAX_TAPS];
	logic signed [SMP_W-1:0] hist_mem [HIST_LEN];
	logic        [SMP_W:0]   ob_mem [BLOCK_LEN];

	logic [LEN_W-1:0]   len_q;
	logic [PART_W-1:0]  parts_q;
	logic [HIST_AW-1:0] hist_wr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [POS_W-1:0]   pos_q;
	logic               blk_done_q;
	logic [SMP_W:0]     ob_rd_q;
	logic [POS_W-1:0]   n_q;
	logic [TAP_AW-1:0]  k_q;
	logic [HIST_AW-1:0] nbase_q;
	logic [HIST_AW-1:0] addr_q;
	logic [FILL_W-1:0]  lim_q;

	logic signed [SMP_W-1:0]   tap_s1, hist_s1;
	logic                      vld_s1;
	logic signed [2*SMP_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]   acc_q;

	logic [LEN_W-1:0]   len_new;
	logic [PART_W-1:0]  parts_new;
	logic [HIST_AW-1:0] rd_addr;
	logic [HIST_AW-1:0] base0;
	logic signed [ACC_W-1:0] rnd;
	logic               hi_ovf, lo_ovf;

	// tap count in use and partition count of a new register value
	always_comb begin
		len_new   = (cfg_wdata > IRL_W'(MAX_TAPS)) ? LEN_W'(MAX_TAPS) : LEN_W'(cfg_wdata);
		parts_new = PART_W'((len_new + LEN_W'(BLOCK_LEN - 1)) >> POS_W);
	end

	assign sts.parts_zero = (parts_q == '0);
	assign sts.pos_last   = (pos_q == POS_W'(BLOCK_LEN - 1));
	assign sts.k_last     = ({1'b0, k_q} == len_q - LEN_W'(1));
	assign sts.n_last     = (n_q == POS_W'(BLOCK_LEN - 1));

	// history read address: first row starts at the oldest sample of the block
	// just closed (the closing word is written at the current write pointer)
	assign rd_addr = cmd.row_start ? nbase_q : addr_q;
	assign base0   = (hist_wr_q >= HIST_AW'(BLOCK_LEN - 1))
		? hist_wr_q - HIST_AW'(BLOCK_LEN - 1)
		: hist_wr_q + HIST_AW'(HIST_LEN - BLOCK_LEN + 1);

	// control state: config, write pointer, fill count, block counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			parts_q    <= '0;
			hist_wr_q  <= '0;
			fill_q     <= '0;
			pos_q      <= '0;
			blk_done_q <= 1'b0;
			n_q        <= '0;
			k_q        <= '0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= cmd.mac_issue && ({{(FILL_W-TAP_AW){1'b0}}, k_q} <= lim_q);
			if (cfg_we) begin
				len_q <= len_new;
				if (parts_new != parts_q) begin
					parts_q    <= parts_new;
					hist_wr_q  <= '0;
					fill_q     <= '0;
					pos_q      <= '0;
					blk_done_q <= 1'b0;
				end
			end else if (cmd.smp_store && !sts.parts_zero) begin
				hist_wr_q <= (hist_wr_q == HIST_AW'(HIST_LEN - 1)) ? '0 : hist_wr_q + 1'b1;
				if (fill_q != FILL_W'(HIST_LEN))
					fill_q <= fill_q + 1'b1;
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.blk_start)
				n_q <= '0;
			else if (cmd.row_finish) begin
				n_q <= n_q + 1'b1;
				if (sts.n_last)
					blk_done_q <= 1'b1;
			end
			if (cmd.row_start)
				k_q <= '0;
			else if (cmd.mac_issue)
				k_q <= k_q + 1'b1;
		end
	end

	// address walkers; valid range of k for the current row
	always_ff @(posedge clk) begin
		if (cmd.blk_start)
			nbase_q <= base0;
		else if (cmd.row_finish)
			nbase_q <= (nbase_q == HIST_AW'(HIST_LEN - 1)) ? '0 : nbase_q + 1'b1;
		if (cmd.row_start) begin
			addr_q <= nbase_q;
			lim_q  <= fill_q + FILL_W'(n_q) - FILL_W'(BLOCK_LEN);
		end else if (cmd.mac_issue)
			addr_q <= (addr_q == '0) ? HIST_AW'(HIST_LEN - 1) : addr_q - 1'b1;
	end

	// memories: registered reads
	always_ff @(posedge clk) begin
		if (cmd.tap_store)
			tap_mem[tap_index] <= tap_value;
		if (cmd.smp_store && !sts.parts_zero)
			hist_mem[hist_wr_q] <= sample;
		tap_s1  <= tap_mem[k_q];
		hist_s1 <= hist_mem[rd_addr];
		if (cmd.row_finish)
			ob_mem[n_q] <= {hi_ovf || lo_ovf,
				hi_ovf ? SMP_W'(2**(SMP_W-1) - 1) : lo_ovf ? {1'b1, {(SMP_W-1){1'b0}}}
				: rnd[SMP_W+22:23]};
		ob_rd_q <= ob_mem[pos_q];
	end

	// multiply, then accumulate
	always_ff @(posedge clk) begin
		if (vld_s1)
			prod_s2 <= tap_s1 * hist_s1;
		else
			prod_s2 <= '0;
		if (cmd.row_start)
			acc_q <= '0;
		else
			acc_q <= acc_q + ACC_W'(prod_s2);
	end

	// round half up to Q1.23 and detect saturation
	always_comb begin
		rnd    = (acc_q + ACC_W'(64'sd4194304)) >>> 23 << 23;
		hi_ovf = !rnd[ACC_W-1] && (rnd[ACC_W-2:SMP_W+22] != '0);
		lo_ovf = rnd[ACC_W-1] && (rnd[ACC_W-2:SMP_W+22] != '1);
	end

	// output register, loaded when an audio word is accepted
	always_ff @(posedge clk) begin
		if (cmd.smp_store) begin
			if (sts.parts_zero || !blk_done_q) begin
				out_sample <= '0;
				clipped    <= 1'b0;
			end else begin
				out_sample <= ob_rd_q[SMP_W-1:0];
				clipped    <= ob_rd_q[SMP_W];
			end
		end
	end
endmodule
`default_nettype wire

/* src/partitioned_block_convolver_core.sv */
// ----------------------------------------------------------------------------
// partitioned_block_convolver_core: block convolver top level
// Streams audio words through a convolution with a loaded impulse response.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel: tuser selects the kind (0 audio sample, 1 tap load).
//  Audio words return one m_* word each, the output for the same position
//  of the previous block (linear convolution delayed by 64 samples).
//  Tap words load one coefficient and return nothing.
//  cfg_we/cfg_wdata write ir_length; a new partition count clears history.
//  The result is registered: m_tvalid rises in the cycle after the audio word is accepted.
//  A tap word leaves the core idle for the next word; an audio word passes
//  through S_SETTLE, and the word closing a block first computes its 64
//  outputs on the single multiply-accumulate unit, one tap per cycle.
//  Reset: silent state, ir_length zero, history treated as zero.
//  A stalled receiver holds the result; no new word is taken until the
//  output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module partitioned_block_convolver_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // sample[23:0], tap_index[35:24], tap_value[59:36]
	input  wire logic        s_tuser,  // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // out_sample[23:0]
	output logic             m_tuser,  // clipped
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_wdata // ir_length
);
	import pbc_pkg::*;

	pbc_cmd_t cmd;
	pbc_sts_t sts;
	logic signed [SMP_W-1:0] out_sample;

	pbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_kind   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pbc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sample     (s_tdata[23:0]),
		.tap_index  (s_tdata[35:24]),
		.tap_value  (s_tdata[59:36]),
		.out_sample (out_sample),
		.clipped    (m_tuser)
	);

	assign m_tdata = out_sample;
endmodule
`default_nettype wire

/* verif/pbc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbc_checker: convolver scoreboard
// Watches the input, output and register ports, keeps its own model of the
// block convolver and compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module pbc_checker
	import pbc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_wdata,
	output int               errors,
	output int               pending
);
	typedef struct {
		logic signed [SMP_W-1:0] y;
		logic                    clip;
	} conv_out_t;

	conv_out_t               conv_out_q[$];
	logic signed [SMP_W-1:0] coef    [MAX_TAPS];
	logic signed [SMP_W-1:0] hist    [HIST_LEN];
	logic signed [SMP_W-1:0] blk_y   [BLOCK_LEN];
	logic                    blk_clip[BLOCK_LEN];
	int                      wr_ptr;
	int                      blk_pos;
	int                      parts;
	int                      taps_len;

	task automatic report_mismatch(input string what);
		$display("%0t pbc_checker: %s", $realtime, what);
		errors++;
	endtask

	task automatic clear_history();
		for (int i = 0; i < HIST_LEN; i++) hist[i] = '0;
		for (int i = 0; i < BLOCK_LEN; i++) begin
			blk_y[i]    = '0;
			blk_clip[i] = 1'b0;
		end
		wr_ptr  = 0;
		blk_pos = 0;
	endtask

	// one block of outputs from the taps and history as they are now
	task automatic convolve_block();
		longint acc;
		longint q;
		int     idx;
		for (int n = 0; n < BLOCK_LEN; n++) begin
			acc = 0;
			for (int k = 0; k < taps_len; k++) begin
				idx = (wr_ptr + 2 * HIST_LEN - BLOCK_LEN + n - k) % HIST_LEN;
				acc += longint'(coef[k]) * longint'(hist[idx]);
			end
			// round half up, then saturate to 24 bits
			q = (acc + 64'sd4194304) >>> 23;
			if (q > 64'sd8388607) begin
				blk_y[n]    = 24'sh7FFFFF;
				blk_clip[n] = 1'b1;
			end else if (q < -64'sd8388608) begin
				blk_y[n]    = 24'sh800000;
				blk_clip[n] = 1'b1;
			end else begin
				blk_y[n]    = q[SMP_W-1:0];
				blk_clip[n] = 1'b0;
			end
		end
	endtask

	task automatic take_word(input logic kind, input logic [63:0] data);
		conv_out_t r;
		if (kind == REQ_TAP) begin
			coef[data[35:24]] = data[59:36];
			return;
		end
		if (parts == 0) begin
			r.y    = '0;
			r.clip = 1'b0;
			conv_out_q.push_back(r);
			return;
		end
		r.y    = blk_y[blk_pos];
		r.clip = blk_clip[blk_pos];
		conv_out_q.push_back(r);
		hist[wr_ptr] = data[23:0];
		wr_ptr = (wr_ptr + 1) % HIST_LEN;
		blk_pos++;
		if (blk_pos >= BLOCK_LEN) begin
			convolve_block();
			blk_pos = 0;
		end
	endtask

	task automatic write_ir_length(input logic [12:0] v);
		int p;
		taps_len = (v > MAX_TAPS) ? MAX_TAPS : int'(v);
		p = (taps_len + BLOCK_LEN - 1) / BLOCK_LEN;
		if (p != parts) begin
			parts = p;
			clear_history();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		conv_out_t e;
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) coef[i] = '0;
			clear_history();
			parts    = 0;
			taps_len = 0;
			errors   = 0;
			conv_out_q.delete();
			pending  = 0;
		end else begin
			// output side first: it belongs to an earlier input word
			if (m_tvalid && m_tready) begin
				if (conv_out_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h clip %b", m_tdata, m_tuser));
				end else begin
					e = conv_out_q.pop_front();
					if (m_tdata !== e.y || m_tuser !== e.clip)
						report_mismatch($sformatf("got %h clip %b, want %h clip %b",
							m_tdata, m_tuser, e.y, e.clip));
				end
			end
			if (cfg_we)
				write_ir_length(cfg_wdata);
			if (s_tvalid && s_tready)
				take_word(s_tuser, s_tdata);
			pending = conv_out_q.size();
		end
	end
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: block convolver testbench
// Drives audio and tap words in random bursts through several ir_length
// settings while the receiver stalls at random; pbc_checker scores results.
// ----------------------------------------------------------------------------
module tb_top;
	import pbc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // sample[23:0], tap_index[35:24], tap_value[59:36]
	logic        s_tuser = 1'b0; // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // out_sample[23:0]
	logic        m_tuser;        // clipped
	logic        cfg_we = 1'b0;
	logic [12:0] cfg_wdata = '0;
	int          errors;
	int          pending;

	bit          tap_loaded[MAX_TAPS];
	int          burst_left = 0;
	bit          no_gaps = 0;
	int          cur_len = 0;
	int          stall_pct = 0;
	int          stall_cnt = 0;

	always #5 clk = ~clk;

	partitioned_block_convolver_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	pbc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	// receiver stall pattern: a stall rate of 0, 30, 70 or 95 percent, redrawn after a random hold
	always @(posedge clk) begin
		if (stall_cnt == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 30;
				2: stall_pct <= 70;
				default: stall_pct <= 95;
			endcase
			stall_cnt <= $urandom_range(50, 400);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// one word on the input channel, in bursts with random gaps between;
	// every caller either sends again or drops valid in the same step
	task automatic send_word(input logic kind, input logic [63:0] data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_sample(input logic [23:0] x);
		send_word(REQ_SAMPLE, {4'b0, 24'h0, 12'h0, x});
	endtask

	task automatic send_tap(input logic [11:0] idx, input logic [23:0] v);
		send_word(REQ_TAP, {4'b0, v, idx, 24'h0});
		tap_loaded[idx] = 1'b1;
	endtask

	function automatic logic [23:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: return 24'($urandom_range(0, 4095)) - 24'd2048;
			default: return 24'($urandom());
		endcase
	endfunction

	// wait until every result is in and any block compute has drained
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (BLOCK_LEN * (cur_len + 5) + 50) @(posedge clk);
	endtask

	// load any missing taps up to the new length, then write the register
	task automatic set_ir_length(input logic [12:0] v);
		int eff;
		eff = (v > MAX_TAPS) ? MAX_TAPS : int'(v);
		for (int i = 0; i < eff; i++)
			if (!tap_loaded[i]) send_tap(i[11:0], rand_value());
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_len = eff;
	endtask

	// mostly samples with some tap rewrites; pauses once until drained
	task automatic random_words(input int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				s_tvalid <= 1'b0;
				burst_left = 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				send_tap(12'($urandom_range(0, MAX_TAPS - 1)), rand_value());
			else
				send_sample(rand_value());
		end
		no_gaps = 0;
	endtask

	initial begin
		#30_000_000;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// silent state: outputs are zero, nothing is stored
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000000);

		// directed: single negative full-scale tap, extremes in and out
		send_tap(12'd0, 24'h800000);
		send_tap(12'd1, 24'h7FFFFF);
		send_tap(12'd4095, 24'h7FFFFF);
		set_ir_length(13'd1);
		for (int i = 0; i < 10; i++) begin
			send_sample(24'h800000);
			send_sample(24'h7FFFFF);
		end
		random_words(90);

		// same partition count keeps history
		set_ir_length(13'd64);
		random_words(80);
		set_ir_length(13'd65);
		random_words(80);
		set_ir_length(13'd130);
		random_words(90);
		set_ir_length(13'd0);
		random_words(10);
		set_ir_length(13'd100);
		random_words(75);

		wait_drained();
		if (errors == 0 && pending == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
